// ===== rtl/vpa_pkg.sv =====
// shared types and constants for the variable partition allocator
package vpa_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int MEMORY_UNITS  = 1024;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADDR_W  = 11;
  localparam int OWNER_W = 8;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_COMPACT = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT,
    S_FREE,
    S_COMPACT,
    S_TAIL,
    S_CLEAR,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input word, reset scan pointer
    logic scan_step;   // evaluate one entry for fit
    logic shift_step;  // move one entry up by one
    logic split;       // write owned entry and free remainder
    logic take_exact;  // write owned entry only
    logic free_step;   // release one entry if owner matches
    logic pack_step;   // move one owned entry down
    logic tail;        // append trailing free entry
    logic clear;       // restore single free partition
    logic fail_nofit;
    logic fail_full;
    logic publish;     // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scan_last;   // pointer at last used entry
    logic  found;
    logic  found_early; // first fit hit this cycle
    logic  need_split;
    logic  table_full;
    logic  shift_done;
    logic  pack_room;
  } stat_t;

endpackage

// ===== rtl/vpa_ctrl.sv =====
// sequencer for allocate, free, compact and clear
module vpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_busy,
  input  vpa_pkg::stat_t st,
  output vpa_pkg::cmd_t  cmd
);

  vpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= vpa_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      vpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (st.kind)
            vpa_pkg::KIND_ALLOC:   state_next = vpa_pkg::S_SCAN;
            vpa_pkg::KIND_FREE:    state_next = vpa_pkg::S_FREE;
            vpa_pkg::KIND_COMPACT: state_next = vpa_pkg::S_COMPACT;
            default:               state_next = vpa_pkg::S_CLEAR;
          endcase
        end
      end
      vpa_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.found_early || st.scan_last) state_next = vpa_pkg::S_DECIDE;
      end
      vpa_pkg::S_DECIDE: begin
        if (!st.found) begin
          cmd.fail_nofit = 1'b1;
          state_next = vpa_pkg::S_DONE;
        end else if (!st.need_split) begin
          cmd.take_exact = 1'b1;
          state_next = vpa_pkg::S_DONE;
        end else if (st.table_full) begin
          cmd.fail_full = 1'b1;
          state_next = vpa_pkg::S_DONE;
        end else begin
          state_next = vpa_pkg::S_SHIFT;
        end
      end
      vpa_pkg::S_SHIFT: begin
        if (st.shift_done) state_next = vpa_pkg::S_SPLIT;
        else               cmd.shift_step = 1'b1;
      end
      vpa_pkg::S_SPLIT: begin
        cmd.split = 1'b1;
        state_next = vpa_pkg::S_DONE;
      end
      vpa_pkg::S_FREE: begin
        cmd.free_step = 1'b1;
        if (st.scan_last) state_next = vpa_pkg::S_DONE;
      end
      vpa_pkg::S_COMPACT: begin
        cmd.pack_step = 1'b1;
        if (st.scan_last) state_next = vpa_pkg::S_TAIL;
      end
      vpa_pkg::S_TAIL: begin
        cmd.tail = st.pack_room;
        state_next = vpa_pkg::S_DONE;
      end
      vpa_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = vpa_pkg::S_DONE;
      end
      vpa_pkg::S_DONE: begin
        if (!out_busy) begin
          cmd.publish = 1'b1;
          state_next = vpa_pkg::S_IDLE;
        end
      end
      default: state_next = vpa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/vpa_dpath.sv =====
// partition table, scan pointer and result assembly
module vpa_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  vpa_pkg::cmd_t                cmd,
  output vpa_pkg::stat_t               st,
  input  logic [1:0]                   fit_policy,
  input  logic [1:0]                   kind,
  input  logic [vpa_pkg::OWNER_W-1:0]  owner_id,
  input  logic [vpa_pkg::ADDR_W-1:0]   request_size,
  output logic [1:0]                   res_status,
  output logic [vpa_pkg::IDX_W-1:0]    res_index,
  output logic [vpa_pkg::ADDR_W-1:0]   res_start,
  output logic [vpa_pkg::CNT_W-1:0]    res_released,
  output logic [vpa_pkg::CNT_W-1:0]    res_count
);

  localparam int N  = vpa_pkg::TABLE_ENTRIES;
  localparam int IW = vpa_pkg::IDX_W;
  localparam int CW = vpa_pkg::CNT_W;
  localparam int AW = vpa_pkg::ADDR_W;
  localparam int OW = vpa_pkg::OWNER_W;

  // table rows are register banks; shift and pack touch two rows a cycle
  logic [AW-1:0] part_start [N];
  logic [AW-1:0] part_size  [N];
  logic [OW-1:0] part_owner [N];
  logic [N-1:0]  part_is_free;
  logic [CW-1:0] used_entries;

  logic [1:0]    op_kind;
  logic [OW-1:0] op_owner;
  logic [AW-1:0] op_need;
  logic [1:0]    op_policy;
  logic [IW-1:0] ptr;      // scan pointer / shift index
  logic [IW-1:0] wptr;     // compact write pointer
  logic [CW-1:0] wcount;
  logic [AW:0]   addr;
  logic          found;
  logic [IW-1:0] pick;
  logic [AW-1:0] pick_size;
  logic [CW-1:0] released;
  logic [1:0]    status;

  logic hit, better, cur_free;
  logic [AW-1:0] cur_size;

  assign cur_free = part_is_free[ptr];
  assign cur_size = part_size[ptr];
  assign hit = cur_free && (cur_size >= op_need);

  always_comb begin
    better = 1'b0;
    if (!found) better = 1'b1;
    else if (op_policy == vpa_pkg::FIT_BEST)  better = cur_size < pick_size;
    else if (op_policy == vpa_pkg::FIT_WORST) better = cur_size > pick_size;
  end

  always_comb begin
    st.kind        = vpa_pkg::kind_t'(kind);
    st.scan_last   = ({1'b0, ptr} + CW'(1)) >= used_entries;
    st.found       = found;
    st.found_early = hit && !found && op_policy != vpa_pkg::FIT_BEST
                     && op_policy != vpa_pkg::FIT_WORST;
    st.need_split  = pick_size > op_need;
    st.table_full  = used_entries >= CW'(N);
    st.shift_done  = ptr == IW'(pick + IW'(1)) || {1'b0, ptr} == CW'(pick) + CW'(1);
    st.pack_room   = wcount < CW'(N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_entries    <= CW'(1);
      part_is_free    <= N'(1);
      part_start[0]   <= '0;
      part_size[0]    <= AW'(vpa_pkg::MEMORY_UNITS);
      found <= 1'b0;
      ptr   <= '0;
    end else begin
      if (cmd.load) begin
        op_kind   <= kind;
        op_owner  <= owner_id;
        op_need   <= request_size;
        op_policy <= fit_policy;
        ptr       <= '0;
        wptr      <= '0;
        wcount    <= '0;
        addr      <= '0;
        found     <= 1'b0;
        released  <= '0;
        status    <= vpa_pkg::ST_OK;
      end
      if (cmd.scan_step) begin
        if (hit && better) begin
          found     <= 1'b1;
          pick      <= ptr;
          pick_size <= cur_size;
        end
        // shift starts from the top of the used region
        if (!(st.found_early || st.scan_last)) ptr <= ptr + IW'(1);
        else ptr <= IW'(used_entries);
      end
      if (cmd.shift_step) begin
        part_start[ptr]   <= part_start[ptr - IW'(1)];
        part_size[ptr]    <= part_size[ptr - IW'(1)];
        part_owner[ptr]   <= part_owner[ptr - IW'(1)];
        part_is_free[ptr] <= part_is_free[ptr - IW'(1)];
        ptr <= ptr - IW'(1);
      end
      if (cmd.split) begin
        part_start[pick + IW'(1)]   <= part_start[pick] + op_need;
        part_size[pick + IW'(1)]    <= pick_size - op_need;
        part_owner[pick + IW'(1)]   <= '0;
        part_is_free[pick + IW'(1)] <= 1'b1;
        used_entries <= used_entries + CW'(1);
      end
      if (cmd.split || cmd.take_exact) begin
        part_size[pick]    <= op_need;
        part_is_free[pick] <= 1'b0;
        part_owner[pick]   <= op_owner;
      end
      if (cmd.fail_nofit) status <= vpa_pkg::ST_NO_FIT;
      if (cmd.fail_full)  status <= vpa_pkg::ST_TABLE_FULL;
      if (cmd.free_step) begin
        if (!cur_free && part_owner[ptr] == op_owner) begin
          part_is_free[ptr] <= 1'b1;
          part_owner[ptr]   <= '0;
          released <= released + CW'(1);
        end
        ptr <= ptr + IW'(1);
      end
      if (cmd.pack_step) begin
        if (!cur_free) begin
          part_start[wptr]   <= addr[AW-1:0];
          part_size[wptr]    <= cur_size;
          part_owner[wptr]   <= part_owner[ptr];
          part_is_free[wptr] <= 1'b0;
          addr   <= addr + {1'b0, cur_size};
          wptr   <= wptr + IW'(1);
          wcount <= wcount + CW'(1);
        end
        ptr <= ptr + IW'(1);
      end
      if (cmd.tail) begin
        part_start[wptr]   <= addr[AW-1:0];
        part_size[wptr]    <= (addr <= (AW+1)'(vpa_pkg::MEMORY_UNITS))
                              ? AW'((AW+1)'(vpa_pkg::MEMORY_UNITS) - addr) : '0;
        part_owner[wptr]   <= '0;
        part_is_free[wptr] <= 1'b1;
      end
      if (op_kind == vpa_pkg::KIND_COMPACT && (cmd.tail || cmd.publish == 1'b0)
          && !cmd.pack_step && !cmd.load && !cmd.scan_step && !cmd.shift_step
          && !cmd.free_step && !cmd.split && !cmd.take_exact && !cmd.clear
          && !cmd.fail_nofit && !cmd.fail_full) begin
        if (cmd.tail) used_entries <= wcount + CW'(1);
        else if (wcount != '0 || used_entries != '0) begin
          // table full case: no tail appended
          if (wcount >= CW'(N)) used_entries <= wcount;
        end
      end
      if (cmd.clear) begin
        part_start[0]   <= '0;
        part_size[0]    <= AW'(vpa_pkg::MEMORY_UNITS);
        part_is_free[0] <= 1'b1;
        used_entries    <= CW'(1);
      end
    end
  end

  // compact with no room: wcount equals table size, used_entries follows above
  always_comb begin
    res_status   = status;
    res_index    = (status == vpa_pkg::ST_OK && op_kind == vpa_pkg::KIND_ALLOC) ? pick : '0;
    res_start    = (status == vpa_pkg::ST_OK && op_kind == vpa_pkg::KIND_ALLOC)
                   ? part_start[pick] : '0;
    res_released = released;
    res_count    = used_entries;
  end

endmodule

// ===== rtl/variable_partition_allocator.sv =====
// top level of the variable partition allocator
// channel | direction | handshake          | word
// in      | input     | in_valid/in_ready  | kind, owner_id, request_size
// out     | output    | out_valid/out_ready| status, entry_index, block_start,
//         |           |                    | released_count, entry_count
// cfg     | input     | apb psel/penable   | fit_policy at address 0
// one word at a time: allocate scans one entry at a time (first fit
// stops early); a split first shifts the entries above the pick up by one
// free and compact walk every used entry; compact may append a free tail
// clear resets the table; reset gives one free partition and first fit
// a pending result register lets the next word enter while out is stalled
module variable_partition_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  owner_id,
  input  logic [10:0] request_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  entry_index,
  output logic [10:0] block_start,
  output logic [5:0]  released_count,
  output logic [5:0]  entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vpa_pkg::cmd_t  cmd;
  vpa_pkg::stat_t st;
  logic [1:0] fit_policy;
  logic [1:0]  r_status;
  logic [4:0]  r_index;
  logic [10:0] r_start;
  logic [5:0]  r_released, r_count;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, fit_policy} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) fit_policy <= vpa_pkg::FIT_FIRST;
    else if (psel && penable && pwrite && paddr == 2'd0) fit_policy <= pwdata[1:0];
  end

  vpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid && !out_ready), .st(st), .cmd(cmd)
  );

  vpa_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .fit_policy(fit_policy),
    .kind(kind), .owner_id(owner_id), .request_size(request_size),
    .res_status(r_status), .res_index(r_index), .res_start(r_start),
    .res_released(r_released), .res_count(r_count)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status         <= r_status;
      entry_index    <= r_index;
      block_start    <= r_start;
      released_count <= r_released;
      entry_count    <= r_count;
    end
  end

endmodule

// ===== tb/tb_variable_partition_allocator.sv =====
// testbench for the variable partition allocator: directed and random words
`timescale 1ns / 100ps

module tb_variable_partition_allocator;

  // expected result of one word
  typedef struct {
    vpa_pkg::status_t status;
    logic [4:0]  entry_index;
    logic [10:0] block_start;
    logic [5:0]  released_count;
    logic [5:0]  entry_count;
  } alloc_result_t;

  // one input word
  typedef struct {
    vpa_pkg::kind_t kind;
    logic [7:0]  owner_id;
    logic [10:0] request_size;
  } alloc_op_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  owner_id;
  logic [10:0] request_size;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [4:0]  entry_index;
  logic [10:0] block_start;
  logic [5:0]  released_count;
  logic [5:0]  entry_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  variable_partition_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .owner_id(owner_id), .request_size(request_size),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_index(entry_index), .block_start(block_start),
    .released_count(released_count), .entry_count(entry_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the partition table
  logic [10:0] tbl_start [vpa_pkg::TABLE_ENTRIES];
  logic [10:0] tbl_size  [vpa_pkg::TABLE_ENTRIES];
  logic [7:0]  tbl_owner [vpa_pkg::TABLE_ENTRIES];
  logic        tbl_free  [vpa_pkg::TABLE_ENTRIES];
  int          tbl_used;
  logic [1:0]  policy;

  // policies, extremes first, unused policy treated as first fit
  logic [1:0]  pol_list [6] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

  alloc_op_t     pending_ops[$];
  alloc_result_t expected_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int alloc_ok = 0;
  int alloc_nofit = 0;
  int alloc_full = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void table_clear();
    for (int i = 0; i < vpa_pkg::TABLE_ENTRIES; i++) begin
      tbl_start[i] = '0;
      tbl_size[i]  = '0;
      tbl_owner[i] = '0;
      tbl_free[i]  = 1'b0;
    end
    tbl_size[0] = 11'(vpa_pkg::MEMORY_UNITS);
    tbl_free[0] = 1'b1;
    tbl_used = 1;
  endfunction

  // apply one word to the shadow table and return what the block should answer
  function automatic alloc_result_t table_apply(alloc_op_t op);
    alloc_result_t r;
    int pick;
    int w;
    int addr;
    r.status = vpa_pkg::ST_OK;
    r.entry_index = '0;
    r.block_start = '0;
    r.released_count = '0;
    case (op.kind)
      vpa_pkg::KIND_ALLOC: begin
        pick = -1;
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_free[i] && tbl_size[i] >= op.request_size) begin
            if (pick < 0) begin
              pick = i;
              if (policy != vpa_pkg::FIT_BEST && policy != vpa_pkg::FIT_WORST) break;
            end else if (policy == vpa_pkg::FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
              pick = i;
            end else if (policy == vpa_pkg::FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          r.status = vpa_pkg::ST_NO_FIT;
        end else if (tbl_size[pick] > op.request_size
                     && tbl_used >= vpa_pkg::TABLE_ENTRIES) begin
          r.status = vpa_pkg::ST_TABLE_FULL;
        end else begin
          if (tbl_size[pick] > op.request_size) begin
            // open a slot right after the chosen entry for the remainder
            for (int j = tbl_used; j > pick + 1; j--) begin
              tbl_start[j] = tbl_start[j-1];
              tbl_size[j]  = tbl_size[j-1];
              tbl_owner[j] = tbl_owner[j-1];
              tbl_free[j]  = tbl_free[j-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + op.request_size;
            tbl_size[pick+1]  = tbl_size[pick] - op.request_size;
            tbl_owner[pick+1] = '0;
            tbl_free[pick+1]  = 1'b1;
            tbl_used++;
          end
          tbl_size[pick]  = op.request_size;
          tbl_free[pick]  = 1'b0;
          tbl_owner[pick] = op.owner_id;
          r.entry_index = pick[4:0];
          r.block_start = tbl_start[pick];
        end
      end
      vpa_pkg::KIND_FREE: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (!tbl_free[i] && tbl_owner[i] == op.owner_id) begin
            tbl_free[i]  = 1'b1;
            tbl_owner[i] = '0;
            r.released_count++;
          end
        end
      end
      vpa_pkg::KIND_COMPACT: begin
        w = 0;
        addr = 0;
        for (int i = 0; i < tbl_used; i++) begin
          if (!tbl_free[i]) begin
            tbl_start[w] = addr[10:0];
            tbl_size[w]  = tbl_size[i];
            tbl_owner[w] = tbl_owner[i];
            tbl_free[w]  = 1'b0;
            addr += tbl_size[i];
            w++;
          end
        end
        // trailing free entry only when there is a slot for it
        if (w < vpa_pkg::TABLE_ENTRIES) begin
          tbl_start[w] = addr[10:0];
          tbl_size[w]  = (addr <= vpa_pkg::MEMORY_UNITS)
                         ? 11'(vpa_pkg::MEMORY_UNITS - addr) : 11'd0;
          tbl_owner[w] = '0;
          tbl_free[w]  = 1'b1;
          w++;
        end
        tbl_used = w;
      end
      default: table_clear();
    endcase
    r.entry_count = tbl_used[5:0];
    return r;
  endfunction

  function automatic void queue_op(vpa_pkg::kind_t k, logic [7:0] o, logic [10:0] s);
    alloc_op_t op;
    op.kind = k;
    op.owner_id = o;
    op.request_size = s;
    pending_ops.push_back(op);
  endfunction

  // sender: bursts of words separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      kind <= vpa_pkg::KIND_ALLOC;
      owner_id <= '0;
      request_size <= '0;
      burst_left <= 0;
      gap_left <= 0;
      table_clear();
    end else if (in_valid && !in_ready) begin
      // hold the word until it is taken
    end else begin
      if (in_valid) begin
        expected_results.push_back(table_apply(pending_ops.pop_front()));
        words_sent++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        // the popped word, if any, is gone; drive the next one
        in_valid <= 1'b1;
        kind <= pending_ops[0].kind;
        owner_id <= pending_ops[0].owner_id;
        request_size <= pending_ops[0].request_size;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stalls follow their own on/off pattern
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.status == vpa_pkg::ST_OK && status == vpa_pkg::ST_OK) alloc_ok++;
        if (status != exp_r.status || entry_index != exp_r.entry_index ||
            block_start != exp_r.block_start ||
            released_count != exp_r.released_count ||
            entry_count != exp_r.entry_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: exp st=%0d idx=%0d start=%0d rel=%0d cnt=%0d",
                     results_seen, exp_r.status, exp_r.entry_index, exp_r.block_start,
                     exp_r.released_count, exp_r.entry_count);
            $display("  got st=%0d idx=%0d start=%0d rel=%0d cnt=%0d",
                     status, entry_index, block_start, released_count, entry_count);
          end
        end
        if (exp_r.status == vpa_pkg::ST_NO_FIT) alloc_nofit++;
        if (exp_r.status == vpa_pkg::ST_TABLE_FULL) alloc_full++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // let any trailing work settle, roughly one full table pass
    repeat (80) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {30'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    policy = value;
  endtask

  // one random phase: mostly allocate/free churn with a few owners
  task automatic random_phase(int count);
    int r;
    logic [7:0]  o;
    logic [10:0] s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      o = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 7));
      s = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                      : 11'($urandom_range(0, 120));
      if (r < 55)
        queue_op(vpa_pkg::KIND_ALLOC, o, s);
      else if (r < 85)
        queue_op(vpa_pkg::KIND_FREE, o, s);
      else if (r < 96)
        queue_op(vpa_pkg::KIND_COMPACT, o, s);
      else
        queue_op(vpa_pkg::KIND_CLEAR, o, s);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    policy = vpa_pkg::FIT_FIRST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero size, oversize, full table, missing owner
    queue_op(vpa_pkg::KIND_ALLOC, 8'd255, 11'd0);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd0, 11'd2047);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd1, 11'd1025);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd2, 11'd100);
    queue_op(vpa_pkg::KIND_FREE, 8'd77, 11'd0);
    queue_op(vpa_pkg::KIND_FREE, 8'd255, 11'd2047);
    queue_op(vpa_pkg::KIND_COMPACT, 8'd0, 11'd0);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd3, 11'd924);
    queue_op(vpa_pkg::KIND_COMPACT, 8'd170, 11'd1365);
    queue_op(vpa_pkg::KIND_CLEAR, 8'd85, 11'd682);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd4, 11'd1024);
    queue_op(vpa_pkg::KIND_COMPACT, 8'd0, 11'd0);
    queue_op(vpa_pkg::KIND_CLEAR, 8'd0, 11'd0);
    // fill the table with small blocks until it is full
    for (int i = 0; i < 33; i++) queue_op(vpa_pkg::KIND_ALLOC, i[7:0], 11'd1);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd9, 11'd1);
    queue_op(vpa_pkg::KIND_ALLOC, 8'd9, 11'd993);
    queue_op(vpa_pkg::KIND_COMPACT, 8'd0, 11'd0);
    queue_op(vpa_pkg::KIND_FREE, 8'd5, 11'd0);
    queue_op(vpa_pkg::KIND_CLEAR, 8'd0, 11'd0);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      write_policy(pol_list[k]);
      random_phase(300);
      wait_drained();
    end

    $display("ran %0d words over all fit policies: %0d ok answers,",
             words_sent, alloc_ok);
    $display("%0d no-fit and %0d table-full allocations", alloc_nofit, alloc_full);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad result words", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vpa_pkg.sv
rtl/vpa_ctrl.sv
rtl/vpa_dpath.sv
rtl/variable_partition_allocator.sv
tb/tb_variable_partition_allocator.sv
